### sv/absb_pkg.sv
// ----------------------------------------------------------------------------
// absb_pkg
// Types, constants and helpers shared by the acked batch sample buffer.
// ----------------------------------------------------------------------------
package absb_pkg;

    localparam int STORE_DEPTH  = 128;
    localparam int BATCH_MAX    = 10;
    localparam int SAMPLE_WIDTH = 64;

    localparam int IDX_W   = $clog2(STORE_DEPTH);
    localparam int FILL_W  = $clog2(STORE_DEPTH + 1);
    localparam int BATCH_W = $clog2(BATCH_MAX + 1);
    localparam int CMP_W   = (FILL_W > BATCH_W) ? FILL_W : BATCH_W;
    localparam int SUM_W   = CMP_W + 1;
    localparam int RAM_W   = SAMPLE_WIDTH + 32;

    localparam int OP_W   = 2;
    localparam int KIND_W = 3;
    localparam int LEN_W  = 4;
    localparam int MB_W   = 4;

    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [OP_W-1:0] OP_ENQUEUE    = 2'd0;
    localparam logic [OP_W-1:0] OP_POLL       = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK        = 2'd2;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NEW_DROPPED    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OLDEST_DROPPED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONNECT        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ENTRY          = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_MAX_BATCH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RECONNECT   = 2'd2;

    localparam logic [MB_W-1:0] MAX_BATCH_RST   = 4'd10;
    localparam logic [31:0]     ACK_TIMEOUT_RST = 32'd15000;
    localparam logic [31:0]     RECONNECT_RST   = 32'd5000;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [SAMPLE_WIDTH-1:0] sample_word;
        logic [31:0]             recorded_at;
        logic [31:0]             now_ms;
        logic                    link_up;
        logic                    session_up;
        logic                    session_idle;
        logic [15:0]             packet_id;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [31:0]             entry_time;
        logic [SAMPLE_WIDTH-1:0] entry_word;
        logic [15:0]             batch_id;
        logic [LEN_W-1:0]        batch_len;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic [MB_W-1:0] max_batch;
        logic [31:0]     ack_limit_ms;
        logic [31:0]     retry_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic enq;
        logic conn;
        logic expire;
        logic start;
        logic rd;
        logic emit;
        logic ack;
        logic disc;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            link_up;
        logic            session_up;
        logic            session_idle;
        logic            conn_due;
        logic            send_ok;
        logic            expire_due;
        logic            out_free;
        logic            last_entry;
    } t_stat;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        d = (s >= SUM_W'(STORE_DEPTH)) ? s - SUM_W'(STORE_DEPTH) : s;
        return d[IDX_W-1:0];
    endfunction

endpackage

### sv/absb_ram.sv
// ----------------------------------------------------------------------------
// absb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module absb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/absb_ctrl.sv
// ----------------------------------------------------------------------------
// absb_ctrl
// Sequencer that takes one item at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module absb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  absb_pkg::t_stat i_stat,
    output absb_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;
    localparam logic [1:0] ST_DATA = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_stat.opcode)
                    absb_pkg::OP_ENQUEUE: begin
                        if (i_stat.out_free) begin
                            o_cmd.enq = 1'b1;
                            n_state   = ST_IDLE;
                        end
                    end
                    absb_pkg::OP_POLL: begin
                        priority if (!i_stat.link_up) begin
                            n_state = ST_IDLE;
                        end else if (!i_stat.session_up) begin
                            if (i_stat.session_idle && i_stat.conn_due) begin
                                if (i_stat.out_free) begin
                                    o_cmd.conn = 1'b1;
                                    n_state    = ST_IDLE;
                                end
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end else if (i_stat.send_ok) begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_SEND;
                        end else begin
                            o_cmd.expire = i_stat.expire_due;
                            n_state      = ST_IDLE;
                        end
                    end
                    absb_pkg::OP_ACK: begin
                        o_cmd.ack = 1'b1;
                        n_state   = ST_IDLE;
                    end
                    absb_pkg::OP_DISCONNECT: begin
                        o_cmd.disc = 1'b1;
                        n_state    = ST_IDLE;
                    end
                endcase
            end
            ST_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_DATA;
                end
            end
            ST_DATA: begin
                o_cmd.emit = 1'b1;
                n_state    = i_stat.last_entry ? ST_IDLE : ST_SEND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/absb_datapath.sv
// ----------------------------------------------------------------------------
// absb_datapath
// Ring store bookkeeping, batch state, sample RAM and the output register.
// ----------------------------------------------------------------------------
module absb_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  absb_pkg::t_cfg      i_cfg,
    input  absb_pkg::t_cmd      i_cmd,
    output absb_pkg::t_stat     o_stat,
    input  absb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output absb_pkg::t_out_item o_out_item
);

    localparam int IDX_W   = absb_pkg::IDX_W;
    localparam int FILL_W  = absb_pkg::FILL_W;
    localparam int BATCH_W = absb_pkg::BATCH_W;
    localparam int CMP_W   = absb_pkg::CMP_W;
    localparam int SUM_W   = absb_pkg::SUM_W;
    localparam int SW      = absb_pkg::SAMPLE_WIDTH;

    absb_pkg::t_in_item  r_item;
    absb_pkg::t_out_item r_out;
    absb_pkg::t_out_item n_out;
    logic                r_out_valid;
    logic                n_out_valid;

    logic [IDX_W-1:0]   r_oldest, n_oldest;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [15:0]        r_pend_id, n_pend_id;
    logic [BATCH_W-1:0] r_pend_len, n_pend_len;
    logic [31:0]        r_pend_sent, n_pend_sent;
    logic [31:0]        r_last_conn, n_last_conn;
    logic [BATCH_W-1:0] r_idx, n_idx;
    logic [BATCH_W-1:0] r_n, n_n;

    logic                   w_pending, w_full, w_empty, w_drop_new;
    logic [31:0]            w_conn_age, w_ack_age;
    logic                   w_expired;
    logic [BATCH_W-1:0]     w_limit, w_batch_n;
    logic [IDX_W-1:0]       w_tail, w_rd_addr, w_oldest_inc, w_oldest_rel;
    logic [FILL_W-1:0]      w_rel;
    logic                   w_ack_match;
    logic                   w_last_entry;
    logic                   w_out_free;
    logic [absb_pkg::RAM_W-1:0] w_rdata;

    assign w_pending  = (r_pend_id != 16'd0);
    assign w_full     = (r_fill == FILL_W'(absb_pkg::STORE_DEPTH));
    assign w_empty    = (r_fill == '0);
    assign w_drop_new = w_full && w_pending;
    assign w_conn_age = r_item.now_ms - r_last_conn;
    assign w_ack_age  = r_item.now_ms - r_pend_sent;
    assign w_expired  = w_pending && (w_ack_age >= i_cfg.ack_limit_ms);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (i_cfg.max_batch == '0) begin
            w_limit = BATCH_W'(1);
        end else if (32'(i_cfg.max_batch) > 32'(absb_pkg::BATCH_MAX)) begin
            w_limit = BATCH_W'(absb_pkg::BATCH_MAX);
        end else begin
            w_limit = BATCH_W'(i_cfg.max_batch);
        end
        w_batch_n = (CMP_W'(r_fill) < CMP_W'(w_limit)) ? BATCH_W'(r_fill) : w_limit;
        w_rel     = (CMP_W'(r_pend_len) > CMP_W'(r_fill)) ? r_fill : FILL_W'(r_pend_len);
    end

    assign w_tail       = absb_pkg::wrap_idx(SUM_W'(r_oldest) + SUM_W'(r_fill));
    assign w_rd_addr    = absb_pkg::wrap_idx(SUM_W'(r_oldest) + SUM_W'(r_idx));
    assign w_oldest_inc = absb_pkg::wrap_idx(SUM_W'(r_oldest) + SUM_W'(1));
    assign w_oldest_rel = absb_pkg::wrap_idx(SUM_W'(r_oldest) + SUM_W'(w_rel));
    assign w_ack_match  = w_pending && (r_item.packet_id == r_pend_id);
    assign w_last_entry = ((BATCH_W + 1)'(r_idx) + (BATCH_W + 1)'(1)) == (BATCH_W + 1)'(r_n);

    absb_ram #(
        .WIDTH (absb_pkg::RAM_W),
        .DEPTH (absb_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq && !w_drop_new),
        .i_waddr (w_tail),
        .i_wdata ({r_item.recorded_at, r_item.sample_word}),
        .i_re    (i_cmd.rd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_oldest    = r_oldest;
        n_fill      = r_fill;
        n_pend_id   = r_pend_id;
        n_pend_len  = r_pend_len;
        n_pend_sent = r_pend_sent;
        n_last_conn = r_last_conn;
        n_idx       = r_idx;
        n_n         = r_n;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.enq) begin
            n_out       = '0;
            n_out_valid = 1'b1;
            priority if (w_drop_new) begin
                n_out.kind = absb_pkg::KIND_NEW_DROPPED;
            end else if (!w_full) begin
                n_fill     = r_fill + FILL_W'(1);
                n_out.kind = absb_pkg::KIND_ACCEPTED;
            end else begin
                n_oldest   = w_oldest_inc;
                n_out.kind = absb_pkg::KIND_OLDEST_DROPPED;
            end
        end

        if (i_cmd.conn) begin
            n_last_conn = r_item.now_ms;
            n_out       = '0;
            n_out.kind  = absb_pkg::KIND_CONNECT;
            n_out_valid = 1'b1;
        end

        if (i_cmd.expire || i_cmd.disc) begin
            n_pend_id = 16'd0;
        end

        if (i_cmd.start) begin
            n_pend_id   = r_item.packet_id;
            n_pend_len  = w_batch_n;
            n_pend_sent = r_item.now_ms;
            n_idx       = '0;
            n_n         = w_batch_n;
        end

        if (i_cmd.emit) begin
            n_out.kind       = absb_pkg::KIND_ENTRY;
            n_out.entry_time = w_rdata[absb_pkg::RAM_W-1:SW];
            n_out.entry_word = w_rdata[SW-1:0];
            n_out.batch_id   = r_pend_id;
            n_out.batch_len  = absb_pkg::LEN_W'(r_n);
            n_out.last       = w_last_entry;
            n_out_valid      = 1'b1;
            n_idx            = r_idx + BATCH_W'(1);
        end

        if (i_cmd.ack && w_ack_match) begin
            n_oldest  = w_oldest_rel;
            n_fill    = r_fill - w_rel;
            n_pend_id = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_fill      <= '0;
            r_pend_id   <= '0;
            r_pend_len  <= '0;
            r_pend_sent <= '0;
            r_last_conn <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_oldest    <= n_oldest;
            r_fill      <= n_fill;
            r_pend_id   <= n_pend_id;
            r_pend_len  <= n_pend_len;
            r_pend_sent <= n_pend_sent;
            r_last_conn <= n_last_conn;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_item;
        end
        r_out <= n_out;
    end

    always_comb begin
        o_stat              = '0;
        o_stat.opcode       = r_item.opcode;
        o_stat.link_up      = r_item.link_up;
        o_stat.session_up   = r_item.session_up;
        o_stat.session_idle = r_item.session_idle;
        o_stat.conn_due     = (w_conn_age >= i_cfg.retry_gap_ms);
        o_stat.send_ok      = (!w_pending || w_expired) && !w_empty
                              && (r_item.packet_id != 16'd0);
        o_stat.expire_due   = w_expired;
        o_stat.out_free     = w_out_free;
        o_stat.last_entry   = w_last_entry;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### sv/acked_batch_sample_buffer.sv
// ----------------------------------------------------------------------------
// acked_batch_sample_buffer
// Ring store of timestamped samples with one acknowledged batch in flight.
// ----------------------------------------------------------------------------
//  channel   handshake                        payload
//  input     i_in_valid / o_in_ready          i_in_item  (t_in_item)
//  output    o_out_valid / i_out_ready        o_out_item (t_out_item)
//  config    psel, penable, pwrite / pready   paddr, pwdata, prdata
//
//  Every item is latched in the idle state and executed in the exec state;
//  a poll that sends n entries then passes through send and data once per
//  entry, since each entry needs a registered RAM read followed by an emit.
//  The store needs no clearing pass; reset clears only the bookkeeping.
//  A new item is taken while the output register still holds a result.
//  A full output register stalls the sequencer until the item is taken.
// ----------------------------------------------------------------------------
module acked_batch_sample_buffer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  absb_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output absb_pkg::t_out_item                 o_out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [absb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    absb_pkg::t_cfg  r_cfg;
    absb_pkg::t_cmd  w_cmd;
    absb_pkg::t_stat w_stat;

    logic                           w_wr;
    logic [absb_pkg::REG_IDX_W-1:0] w_reg_idx;

    assign w_wr      = psel && penable && pwrite;
    assign w_reg_idx = paddr[absb_pkg::APB_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_batch    <= absb_pkg::MAX_BATCH_RST;
            r_cfg.ack_limit_ms <= absb_pkg::ACK_TIMEOUT_RST;
            r_cfg.retry_gap_ms <= absb_pkg::RECONNECT_RST;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                absb_pkg::REG_MAX_BATCH:   r_cfg.max_batch <= pwdata[absb_pkg::MB_W-1:0];
                absb_pkg::REG_ACK_TIMEOUT: r_cfg.ack_limit_ms <= pwdata;
                absb_pkg::REG_RECONNECT:   r_cfg.retry_gap_ms <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            absb_pkg::REG_MAX_BATCH:   prdata = 32'(r_cfg.max_batch);
            absb_pkg::REG_ACK_TIMEOUT: prdata = r_cfg.ack_limit_ms;
            absb_pkg::REG_RECONNECT:   prdata = r_cfg.retry_gap_ms;
            default:                   prdata = 32'd0;
        endcase
    end

    absb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    absb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.enq || w_cmd.conn || w_cmd.emit) |-> (!o_out_valid || i_out_ready))
        else $error("output register loaded while a result is still held");

    a_emit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> $past(w_cmd.rd))
        else $error("batch entry emitted without a preceding store read");

    a_entry_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.kind == absb_pkg::KIND_ENTRY))
        |-> (o_out_item.batch_len != '0))
        else $error("batch entry carries a zero batch length");
`endif

endmodule
